// ===== hdl/dll_pkg.sv =====
// Shared types and constants of the bounded doubly linked list.
package dll_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OP_W            = 3;
    localparam int STAT_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_PREPEND  = 3'd1,
        OP_DELETE   = 3'd2,
        OP_DUMP_FWD = 3'd3,
        OP_DUMP_BWD = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS1,
        S_INS2,
        S_SRCH,
        S_UNL1,
        S_UNL2,
        S_DUMP,
        S_RES
    } t_state;

    // per-field write enables of the node store
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } t_mem_we;

endpackage

// ===== hdl/dll_store.sv =====
// Node store: value, next link and previous link, one shared address, registered read.
module dll_store #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic [AW-1:0]                 i_addr,
    input  logic                          i_re,
    input  dll_pkg::t_mem_we              i_we,
    input  logic signed [VALUE_WIDTH-1:0] i_wval,
    input  logic [LW-1:0]                 i_wnxt,
    input  logic [LW-1:0]                 i_wprv,
    output logic signed [VALUE_WIDTH-1:0] o_rval,
    output logic [LW-1:0]                 o_rnxt,
    output logic [LW-1:0]                 o_rprv
);

    logic signed [VALUE_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [LW-1:0]                 r_nxt_mem [CAPACITY];
    logic [LW-1:0]                 r_prv_mem [CAPACITY];

    logic signed [VALUE_WIDTH-1:0] r_rd_val;
    logic [LW-1:0]                 r_rd_nxt;
    logic [LW-1:0]                 r_rd_prv;

    always_ff @(posedge i_clk) begin
        if (i_we.val) begin
            r_val_mem[i_addr] <= i_wval;
        end
        if (i_we.nxt) begin
            r_nxt_mem[i_addr] <= i_wnxt;
        end
        if (i_we.prv) begin
            r_prv_mem[i_addr] <= i_wprv;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_val <= r_val_mem[i_addr];
            r_rd_nxt <= r_nxt_mem[i_addr];
            r_rd_prv <= r_prv_mem[i_addr];
        end
    end

    assign o_rval = r_rd_val;
    assign o_rnxt = r_rd_nxt;
    assign o_rprv = r_rd_prv;

endmodule

// ===== hdl/dll_obuf.sv =====
// Output register between the sequencer and the result stream.
module dll_obuf #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  dll_pkg::t_status              i_status,
    input  logic signed [VALUE_WIDTH-1:0] i_data,
    input  logic                          i_last,
    input  logic [CNT_W-1:0]              i_count,
    output logic                          o_ready,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic [dll_pkg::STAT_W-1:0]    o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);

    logic                          r_valid;
    dll_pkg::t_status              r_status;
    logic signed [VALUE_WIDTH-1:0] r_data;
    logic                          r_last;
    logic [CNT_W-1:0]              r_count;

    assign o_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_status <= i_status;
            r_data   <= i_data;
            r_last   <= i_last;
            r_count  <= i_count;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_count, r_data});
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_last;

endmodule

// ===== hdl/dll_ctrl.sv =====
// Sequencer: list pointers, free map and the node store access sequence per request.
module dll_ctrl #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dll_pkg::OP_W-1:0]      i_op,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    // node store
    output logic [AW-1:0]                 o_addr,
    output logic                          o_re,
    output dll_pkg::t_mem_we              o_we,
    output logic signed [VALUE_WIDTH-1:0] o_wval,
    output logic [LW-1:0]                 o_wnxt,
    output logic [LW-1:0]                 o_wprv,
    input  logic signed [VALUE_WIDTH-1:0] i_rval,
    input  logic [LW-1:0]                 i_rnxt,
    input  logic [LW-1:0]                 i_rprv,
    // result register
    input  logic                          i_ob_ready,
    output logic                          o_push,
    output dll_pkg::t_status              o_status,
    output logic signed [VALUE_WIDTH-1:0] o_data,
    output logic                          o_last,
    output logic [LW-1:0]                 o_count
);

    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    dll_pkg::t_state               r_state,  n_state;
    logic [LW-1:0]                 r_head,   n_head;
    logic [LW-1:0]                 r_tail,   n_tail;
    logic [LW-1:0]                 r_count,  n_count;
    logic [CAPACITY-1:0]           r_free,   n_free;
    logic                          r_dir,    n_dir;
    logic signed [VALUE_WIDTH-1:0] r_val,    n_val;
    logic [LW-1:0]                 r_ptr,    n_ptr;
    logic [LW-1:0]                 r_pv,     n_pv;
    logic [LW-1:0]                 r_nx,     n_nx;
    dll_pkg::t_status              r_status, n_status;

    logic          w_slot_ok;
    logic [LW-1:0] w_slot;
    logic [LW-1:0] w_mem_ptr;
    logic [LW-1:0] w_step;

    // lowest free slot
    always_comb begin
        w_slot_ok = 1'b0;
        w_slot    = NIL;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_slot_ok = 1'b1;
                w_slot    = LW'(i);
            end
        end
    end

    assign w_step = r_dir ? i_rnxt : i_rprv;
    assign o_addr = w_mem_ptr[AW-1:0];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dll_pkg::S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_count <= '0;
            r_free  <= '1;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir    <= n_dir;
        r_val    <= n_val;
        r_ptr    <= n_ptr;
        r_pv     <= n_pv;
        r_nx     <= n_nx;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_free   = r_free;
        n_dir    = r_dir;
        n_val    = r_val;
        n_ptr    = r_ptr;
        n_pv     = r_pv;
        n_nx     = r_nx;
        n_status = r_status;
        o_ready  = 1'b0;
        w_mem_ptr = r_ptr;
        o_re     = 1'b0;
        o_we     = '0;
        o_wval   = r_val;
        o_wnxt   = NIL;
        o_wprv   = NIL;
        o_push   = 1'b0;
        o_status = r_status;
        o_data   = '0;
        o_last   = 1'b1;

        case (r_state)
            dll_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_val = i_value;
                    case (dll_pkg::t_op'(i_op))
                        dll_pkg::OP_APPEND, dll_pkg::OP_PREPEND: begin
                            n_dir = (dll_pkg::t_op'(i_op) == dll_pkg::OP_APPEND);
                            if (w_slot_ok) begin
                                n_ptr = w_slot;
                                n_free[w_slot[AW-1:0]] = 1'b0;
                                n_state = dll_pkg::S_INS1;
                            end else begin
                                n_status = dll_pkg::ST_FULL;
                                n_state  = dll_pkg::S_RES;
                            end
                        end
                        dll_pkg::OP_DELETE: begin
                            if (r_head == NIL) begin
                                n_status = dll_pkg::ST_NOT_FOUND;
                                n_state  = dll_pkg::S_RES;
                            end else begin
                                w_mem_ptr = r_head;
                                o_re    = 1'b1;
                                n_ptr   = r_head;
                                n_state = dll_pkg::S_SRCH;
                            end
                        end
                        dll_pkg::OP_DUMP_FWD, dll_pkg::OP_DUMP_BWD: begin
                            n_dir = (dll_pkg::t_op'(i_op) == dll_pkg::OP_DUMP_FWD);
                            if (r_head == NIL) begin
                                n_status = dll_pkg::ST_EMPTY;
                                n_state  = dll_pkg::S_RES;
                            end else begin
                                w_mem_ptr = (dll_pkg::t_op'(i_op) == dll_pkg::OP_DUMP_FWD)
                                          ? r_head : r_tail;
                                o_re    = 1'b1;
                                n_state = dll_pkg::S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // new node; r_dir set means append
            dll_pkg::S_INS1: begin
                o_we   = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
                o_wnxt = r_dir ? NIL : r_head;
                o_wprv = r_dir ? r_tail : NIL;
                if (r_head == NIL) begin
                    n_head   = r_ptr;
                    n_tail   = r_ptr;
                    n_count  = r_count + 1'b1;
                    n_status = dll_pkg::ST_OK;
                    n_state  = dll_pkg::S_RES;
                end else begin
                    n_state = dll_pkg::S_INS2;
                end
            end

            dll_pkg::S_INS2: begin
                if (r_dir) begin
                    w_mem_ptr = r_tail;
                    o_we.nxt  = 1'b1;
                    o_wnxt    = r_ptr;
                    n_tail    = r_ptr;
                end else begin
                    w_mem_ptr = r_head;
                    o_we.prv  = 1'b1;
                    o_wprv    = r_ptr;
                    n_head    = r_ptr;
                end
                n_count  = r_count + 1'b1;
                n_status = dll_pkg::ST_OK;
                n_state  = dll_pkg::S_RES;
            end

            dll_pkg::S_SRCH: begin
                if (i_rval == r_val) begin
                    n_pv    = i_rprv;
                    n_nx    = i_rnxt;
                    n_state = dll_pkg::S_UNL1;
                end else if (i_rnxt == NIL) begin
                    n_status = dll_pkg::ST_NOT_FOUND;
                    n_state  = dll_pkg::S_RES;
                end else begin
                    w_mem_ptr = i_rnxt;
                    o_re      = 1'b1;
                    n_ptr     = i_rnxt;
                end
            end

            dll_pkg::S_UNL1: begin
                if (r_pv != NIL) begin
                    w_mem_ptr = r_pv;
                    o_we.nxt  = 1'b1;
                    o_wnxt    = r_nx;
                end else begin
                    n_head = r_nx;
                end
                n_state = dll_pkg::S_UNL2;
            end

            dll_pkg::S_UNL2: begin
                if (r_nx != NIL) begin
                    w_mem_ptr = r_nx;
                    o_we.prv  = 1'b1;
                    o_wprv    = r_pv;
                end else begin
                    n_tail = r_pv;
                end
                n_free[r_ptr[AW-1:0]] = 1'b1;
                n_count  = r_count - 1'b1;
                n_status = dll_pkg::ST_OK;
                n_state  = dll_pkg::S_RES;
            end

            dll_pkg::S_DUMP: begin
                o_status = dll_pkg::ST_OK;
                o_data   = i_rval;
                o_last   = (w_step == NIL);
                if (i_ob_ready) begin
                    o_push = 1'b1;
                    if (w_step == NIL) begin
                        n_state = dll_pkg::S_IDLE;
                    end else begin
                        w_mem_ptr = w_step;
                        o_re      = 1'b1;
                    end
                end
            end

            dll_pkg::S_RES: begin
                if (i_ob_ready) begin
                    o_push  = 1'b1;
                    n_state = dll_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dll_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bounded_doubly_linked_list.sv =====
// Top level of the bounded doubly linked list.
//
// One request at a time: append (tuser 0), prepend (1), delete first match (2), dump forward
// (3), dump backward (4); other codes are taken and dropped. Nodes live in a single-port node
// store with a registered read, so the store port sets the pace. An insert writes the new
// node into the lowest free slot and then links the old tail or head to it (not on an empty
// list); a delete reads and compares nodes from the head on, then relinks both neighbours
// and frees the slot; a dump hands over one result per node read. The output register shows
// each result in the cycle after it is handed over, and a held-off output stalls the sequencer.
// A full list rejects inserts (status 1); a missed delete gives status 2; an empty dump gives
// one result with status 3. Results carry tlast on the final one of each request.
module bounded_doubly_linked_list #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF,
    localparam int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW          = $clog2(CAPACITY + 1),
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + LW + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]      i_s_axis_tdata,  // item_value
    input  logic [dll_pkg::OP_W-1:0]   i_s_axis_tuser,  // op
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]     o_m_axis_tdata,  // data_value, entry_count
    output logic [dll_pkg::STAT_W-1:0] o_m_axis_tuser,  // status
    output logic                       o_m_axis_tlast   // last_of_run
);

    logic [AW-1:0]                 w_addr;
    logic                          w_re;
    dll_pkg::t_mem_we              w_we;
    logic signed [VALUE_WIDTH-1:0] w_wval;
    logic [LW-1:0]                 w_wnxt;
    logic [LW-1:0]                 w_wprv;
    logic signed [VALUE_WIDTH-1:0] w_rval;
    logic [LW-1:0]                 w_rnxt;
    logic [LW-1:0]                 w_rprv;

    logic                          w_ob_ready;
    logic                          w_push;
    dll_pkg::t_status              w_status;
    logic signed [VALUE_WIDTH-1:0] w_data;
    logic                          w_last;
    logic [LW-1:0]                 w_count;

    dll_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_op       (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_addr     (w_addr),
        .o_re       (w_re),
        .o_we       (w_we),
        .o_wval     (w_wval),
        .o_wnxt     (w_wnxt),
        .o_wprv     (w_wprv),
        .i_rval     (w_rval),
        .i_rnxt     (w_rnxt),
        .i_rprv     (w_rprv),
        .i_ob_ready (w_ob_ready),
        .o_push     (w_push),
        .o_status   (w_status),
        .o_data     (w_data),
        .o_last     (w_last),
        .o_count    (w_count)
    );

    dll_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .i_re   (w_re),
        .i_we   (w_we),
        .i_wval (w_wval),
        .i_wnxt (w_wnxt),
        .i_wprv (w_wprv),
        .o_rval (w_rval),
        .o_rnxt (w_rnxt),
        .o_rprv (w_rprv)
    );

    dll_obuf #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_obuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .i_status        (w_status),
        .i_data          (w_data),
        .i_last          (w_last),
        .i_count         (w_count),
        .o_ready         (w_ob_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_ob_ready)
        else $error("result pushed while output register is full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= LW'(CAPACITY))
        else $error("node count above capacity");

    a_run_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_last) |-> (w_status == dll_pkg::ST_OK))
        else $error("non-final result without ok status");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push || w_re || (w_we != '0)) |-> !(i_s_axis_tvalid && o_s_axis_tready && w_push))
        else $error("request taken while a result is being pushed");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_status != dll_pkg::ST_OK || w_last) && w_status != dll_pkg::ST_OK)
            |-> (w_data == '0))
        else $error("non-dump result carries data");

endmodule

// ===== dv/bounded_doubly_linked_list_test.sv =====
// Self-checking stream testbench for the bounded doubly linked list, with a list predictor.
`timescale 1ns / 100ps

module bounded_doubly_linked_list_test;

    localparam int CAP            = dll_pkg::CAPACITY_DEF;
    localparam int VW             = dll_pkg::VALUE_WIDTH_DEF;
    localparam int OP_W           = dll_pkg::OP_W;
    localparam int STAT_W         = dll_pkg::STAT_W;
    localparam int AW             = $clog2(CAP);
    localparam int LW             = $clog2(CAP + 1);
    localparam int IN_W           = ((VW + 7) / 8) * 8;
    localparam int OUT_W          = ((VW + LW + 7) / 8) * 8;
    localparam logic [LW-1:0] NIL = LW'(CAP);
    localparam int POOL_AW        = 3;
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
    localparam int STALL_AT       = 60;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int QUIET_TAIL     = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [VW-1:0]   value;
    } t_req;

    typedef struct packed {
        dll_pkg::t_status status;
        logic [VW-1:0]    value;
        logic             last;
        logic [LW-1:0]    count;
    } t_result;

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;    // item_value
    logic [OP_W-1:0]   s_tuser  = '0;    // op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // data_value, entry_count
    logic [STAT_W-1:0] m_tuser;          // status
    logic              m_tlast;          // last_of_run

    // predicted list state
    logic [VW-1:0] node_val  [CAP];
    logic [LW-1:0] link_fwd  [CAP];
    logic [LW-1:0] link_bwd  [CAP];
    logic          slot_free [CAP];
    logic [LW-1:0] head_idx;
    logic [LW-1:0] tail_idx;
    logic [LW-1:0] node_total;

    t_req    pending_reqs[$];
    t_result expected_results[$];
    logic [VW-1:0] value_pool[1 << POOL_AW];

    logic in_fire     = 1'b0;
    bit   gen_done    = 1'b0;
    bit   hold_done   = 1'b0;
    int   hold_left   = 0;
    int   tx_idle     = 0;
    int   rx_idle     = 0;
    int   results_seen = 0;
    int   mismatches  = 0;
    int   dead_cycles = 0;

    bounded_doubly_linked_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit quiet();
        return gen_done && pending_reqs.size() <= QUIET_TAIL;
    endfunction

    task automatic list_reset();
        for (int i = 0; i < CAP; i++) begin
            node_val[AW'(i)]  = '0;
            link_fwd[AW'(i)]  = '0;
            link_bwd[AW'(i)]  = '0;
            slot_free[AW'(i)] = 1'b1;
        end
        head_idx   = NIL;
        tail_idx   = NIL;
        node_total = '0;
    endtask

    task automatic push_result(dll_pkg::t_status st, logic [VW-1:0] v, logic last);
        t_result r;
        r.status = st;
        r.value  = v;
        r.last   = last;
        r.count  = node_total;
        expected_results.push_back(r);
    endtask

    task automatic list_apply(t_req rq);
        int            slot;
        int            steps;
        bit            fwd;
        logic [LW-1:0] p;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
        case (rq.op)
            dll_pkg::OP_APPEND, dll_pkg::OP_PREPEND: begin
                slot = -1;
                for (int i = CAP - 1; i >= 0; i--) begin
                    if (slot_free[AW'(i)]) slot = i;
                end
                if (slot < 0) begin
                    push_result(dll_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    slot_free[slot[AW-1:0]] = 1'b0;
                    node_val[slot[AW-1:0]]  = rq.value;
                    link_fwd[slot[AW-1:0]]  = NIL;
                    link_bwd[slot[AW-1:0]]  = NIL;
                    if (head_idx >= NIL || tail_idx >= NIL) begin
                        head_idx = LW'(slot);
                        tail_idx = LW'(slot);
                    end else if (rq.op == dll_pkg::OP_PREPEND) begin
                        link_fwd[slot[AW-1:0]]     = head_idx;
                        link_bwd[head_idx[AW-1:0]] = LW'(slot);
                        head_idx                   = LW'(slot);
                    end else begin
                        link_fwd[tail_idx[AW-1:0]] = LW'(slot);
                        link_bwd[slot[AW-1:0]]     = tail_idx;
                        tail_idx                   = LW'(slot);
                    end
                    node_total++;
                    push_result(dll_pkg::ST_OK, '0, 1'b1);
                end
            end
            dll_pkg::OP_DELETE: begin
                p     = head_idx;
                steps = 0;
                while (p < NIL && steps < CAP && node_val[p[AW-1:0]] != rq.value) begin
                    p = link_fwd[p[AW-1:0]];
                    steps++;
                end
                if (p >= NIL || steps >= CAP) begin
                    push_result(dll_pkg::ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    nxt = link_fwd[p[AW-1:0]];
                    prv = link_bwd[p[AW-1:0]];
                    if (prv < NIL) link_fwd[prv[AW-1:0]] = nxt;
                    else           head_idx = nxt;
                    if (nxt < NIL) link_bwd[nxt[AW-1:0]] = prv;
                    else           tail_idx = prv;
                    slot_free[p[AW-1:0]] = 1'b1;
                    if (node_total > 0) node_total--;
                    push_result(dll_pkg::ST_OK, '0, 1'b1);
                end
            end
            dll_pkg::OP_DUMP_FWD, dll_pkg::OP_DUMP_BWD: begin
                fwd = (rq.op == dll_pkg::OP_DUMP_FWD);
                p   = fwd ? head_idx : tail_idx;
                if (p >= NIL) begin
                    push_result(dll_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    steps = 0;
                    while (p < NIL && steps < CAP) begin
                        nxt = fwd ? link_fwd[p[AW-1:0]] : link_bwd[p[AW-1:0]];
                        push_result(dll_pkg::ST_OK, node_val[p[AW-1:0]],
                                    !(nxt < NIL && steps + 1 < CAP));
                        steps++;
                        p = nxt;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected status %0d value %h last %b count %0d",
                     $time, what, want.status, want.value, want.last, want.count);
            $display("%0t %s: actual   status %0d value %h last %b count %0d",
                     $time, what, got.status, got.value, got.last, got.count);
        end
    endtask

    task automatic queue_req(logic [OP_W-1:0] op, logic [VW-1:0] v);
        t_req rq;
        rq.op    = op;
        rq.value = v;
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [VW-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return value_pool[POOL_AW'($urandom_range(0, 7))];
        return VW'($urandom);
    endfunction

    // request side: predict on acceptance
    always @(posedge i_clk) begin : accept_requests
        t_req rq;
        in_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            rq.op    = s_tuser;
            rq.value = s_tdata[VW-1:0];
            list_apply(rq);
        end
    end

    always @(negedge i_clk) begin : drive_requests
        t_req rq;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (tx_idle > 0) begin
                tx_idle--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_tdata  <= IN_W'(rq.value);
                s_tuser  <= rq.op;
                s_tvalid <= 1'b1;
                if (!quiet() && $urandom_range(0, 7) == 0) tx_idle = $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= STALL_AT) begin
            // long hold-off so the block backs up into its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet() && $urandom_range(0, 9) == 0) rx_idle = $urandom_range(1, 10);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status = dll_pkg::t_status'(m_tuser);
            got.value  = m_tdata[VW-1:0];
            got.last   = m_tlast;
            got.count  = m_tdata[VW+LW-1:VW];
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.value !== want.value ||
                    got.last !== want.last || got.count !== want.count)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_doubly_linked_list verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        list_reset();
        value_pool[0] = '0;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++) value_pool[POOL_AW'(i)] = VW'($urandom);

        // directed: empty list, extremes, head/middle/tail delete, miss, bad codes
        queue_req(dll_pkg::OP_DUMP_FWD, 32'h1234_5678);
        queue_req(dll_pkg::OP_DUMP_BWD, 32'h0);
        queue_req(dll_pkg::OP_DELETE, 32'h5);
        queue_req(dll_pkg::OP_APPEND, 32'h7fff_ffff);
        queue_req(dll_pkg::OP_APPEND, 32'h8000_0000);
        queue_req(dll_pkg::OP_PREPEND, 32'h0);
        queue_req(dll_pkg::OP_PREPEND, 32'hffff_ffff);
        queue_req(dll_pkg::OP_APPEND, 32'h7fff_ffff);
        queue_req(dll_pkg::OP_DUMP_FWD, 32'hffff_ffff);
        queue_req(dll_pkg::OP_DUMP_BWD, 32'h0);
        queue_req(dll_pkg::OP_DELETE, 32'h7fff_ffff);
        queue_req(dll_pkg::OP_DELETE, 32'hffff_ffff);
        queue_req(dll_pkg::OP_DELETE, 32'h7fff_ffff);
        queue_req(dll_pkg::OP_DELETE, 32'h0001_2345);
        queue_req(OP_RSVD_LO, 32'h0);
        queue_req(OP_RSVD_LO + 1'b1, 32'hffff_ffff);
        queue_req(OP_RSVD_HI, 32'h8000_0000);
        queue_req(dll_pkg::OP_DUMP_FWD, 32'h0);
        queue_req(dll_pkg::OP_DELETE, 32'h8000_0000);
        queue_req(dll_pkg::OP_DELETE, 32'h0);
        queue_req(dll_pkg::OP_DUMP_BWD, 32'h0);
        queue_req(dll_pkg::OP_APPEND, 32'h55aa_55aa);
        queue_req(dll_pkg::OP_PREPEND, 32'haa55_aa55);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender pause: let every result of the directed part drain
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);

        // fill past capacity, then dump a full list both ways
        for (int i = 0; i < 18; i++)
            queue_req($urandom_range(0, 1) ? dll_pkg::OP_PREPEND : dll_pkg::OP_APPEND,
                      pick_value());
        queue_req(dll_pkg::OP_DUMP_FWD, VW'($urandom));
        queue_req(dll_pkg::OP_DUMP_BWD, VW'($urandom));

        for (int i = 0; i < 66; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      queue_req(dll_pkg::OP_APPEND, pick_value());
            else if (r < 50) queue_req(dll_pkg::OP_PREPEND, pick_value());
            else if (r < 75) queue_req(dll_pkg::OP_DELETE, pick_value());
            else if (r < 85) queue_req(dll_pkg::OP_DUMP_FWD, VW'($urandom));
            else if (r < 95) queue_req(dll_pkg::OP_DUMP_BWD, VW'($urandom));
            else             queue_req(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                                       VW'($urandom));
        end

        // drain through deletes of pooled values
        for (int i = 0; i < 20; i++) begin
            if (i % 5 == 4) queue_req(dll_pkg::OP_DUMP_FWD, VW'($urandom));
            else            queue_req(dll_pkg::OP_DELETE,
                                      value_pool[POOL_AW'($urandom_range(0, 7))]);
        end
        queue_req(dll_pkg::OP_DUMP_BWD, VW'($urandom));
        gen_done = 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("bounded_doubly_linked_list verification clean");
        else
            $display("bounded_doubly_linked_list verification failed");
        $finish;
    end

endmodule
